// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the speed estimator.
// Each macro takes a label, the clock, the reset and the two property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/aspd_pkg.sv -----
// Package for the angle-to-speed estimator: constants, register indexes,
// sequencer state and control types. No dependencies.
package aspd_pkg;

   localparam int ANGLE_WIDTH_DEF = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_RATE = 1'b1;

   localparam logic [CSR_DATA_W-1:0] ALPHA_RESET = 16'd6554;
   localparam logic [CSR_DATA_W-1:0] RATE_RESET  = 16'd500;

   // Unity weight in Q1.15
   localparam int ALPHA_W    = 17;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd32768;
   localparam int ALPHA_FRAC = 15;

   // Multiplier second operand: 17-bit unsigned value plus a sign bit
   localparam int OPB_W = 18;

   localparam int PI_Q12     = 12868;
   localparam int TWO_PI_Q12 = 25736;

   localparam int SPEED_W = 32;
   localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MUL_RATE,
      ST_CLIP,
      ST_MUL_ALPHA,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic delta;
      logic mul_rate;
      logic clip;
      logic mul_alpha;
      logic update;
      logic emit;
   } ctrl_type;

endpackage

// ----- hdl/aspd_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on nothing; widths come from the instantiating module.
module aspd_mul #(
   parameter int A_W = 33,
   parameter int B_W = 18
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [A_W-1:0]       op_a,
   input  logic signed [B_W-1:0]       op_b,
   output logic signed [A_W+B_W-1:0]   prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- hdl/aspd_ctrl.sv -----
// Sequencer for the speed estimator: walks one sample through the delta,
// two multiplier passes, clipping, update and output load. Uses aspd_pkg.
module aspd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               have_prev,
   input  logic               out_free,
   output logic               req_ready,
   output aspd_pkg::ctrl_type ctrl
);
   import aspd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DELTA;
         end
         ST_DELTA: begin
            // first sample only seeds the previous angle
            state_in = have_prev ? ST_MUL_RATE : ST_EMIT;
         end
         ST_MUL_RATE:  state_in = ST_CLIP;
         ST_CLIP:      state_in = ST_MUL_ALPHA;
         ST_MUL_ALPHA: state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_DELTA:     ctrl.delta     = 1'b1;
         ST_MUL_RATE:  ctrl.mul_rate  = 1'b1;
         ST_CLIP:      ctrl.clip      = 1'b1;
         ST_MUL_ALPHA: ctrl.mul_alpha = 1'b1;
         ST_UPDATE:    ctrl.update    = 1'b1;
         ST_EMIT:      ctrl.emit      = out_free;
         default: begin
            ctrl      = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/angle_to_speed_ema_estimator.sv -----
// Angle-difference speed estimator with an EMA filter. Each accepted angle
// beat (signed Q3.12 rad) yields one speed beat (signed Q19.12 rad/s) plus a
// clip flag. A sample holds the block from its accept until the sequencer is
// back in idle, and its result is registered after these steps (the first
// sample after reset only seeds the previous angle and skips to the load):
// one delta step, two passes through the single shared multiplier (rate, then
// alpha), each followed by a clip/update step, then the load of the result
// register, which waits as long as the previous result is held.
// The next sample is taken once the sequencer is back in idle, while a
// finished result may still wait.
// Depends on aspd_pkg, aspd_ctrl, aspd_mul and assert_macros.svh.
`include "assert_macros.svh"

module angle_to_speed_ema_estimator #(
   parameter int ANGLE_WIDTH = aspd_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ANGLE_WIDTH-1:0]       req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [aspd_pkg::SPEED_W-1:0] rsp_speed,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  logic [aspd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aspd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import aspd_pkg::*;

   localparam int DELTA_W = (ANGLE_WIDTH >= 16) ? ANGLE_WIDTH + 1 : 17;
   localparam int OPA_W   = (DELTA_W > SPEED_W + 1) ? DELTA_W : SPEED_W + 1;
   localparam int P_W     = OPA_W + OPB_W;
   localparam int SUM_W   = P_W - ALPHA_FRAC + 1;

   localparam logic signed [DELTA_W-1:0] PI_D     = DELTA_W'(PI_Q12);
   localparam logic signed [DELTA_W-1:0] NEG_PI_D = -DELTA_W'(PI_Q12);
   localparam logic signed [DELTA_W-1:0] TWO_PI_D = DELTA_W'(TWO_PI_Q12);
   localparam logic signed [P_W-1:0]     P_MAX    = P_W'(S32_MAX);
   localparam logic signed [P_W-1:0]     P_MIN    = P_W'(S32_MIN);
   localparam logic signed [SUM_W-1:0]   SUM_MAX  = SUM_W'(S32_MAX);
   localparam logic signed [SUM_W-1:0]   SUM_MIN  = SUM_W'(S32_MIN);
   localparam logic signed [SPEED_W-1:0] SPD_MAX  = SPEED_W'(S32_MAX);
   localparam logic signed [SPEED_W-1:0] SPD_MIN  = SPEED_W'(S32_MIN);

   ctrl_type ctrl;
   logic     out_free;

   logic [CSR_DATA_W-1:0]        alpha_ff;
   logic [CSR_DATA_W-1:0]        rate_ff;
   logic signed [ANGLE_WIDTH-1:0] angle_ff;
   logic signed [ANGLE_WIDTH-1:0] prev_ff;
   logic                         have_prev_ff;
   logic signed [SPEED_W-1:0]    est_ff;
   logic signed [DELTA_W-1:0]    delta_ff;
   logic signed [SPEED_W:0]      diff_ff;
   logic                         sat_ff;
   logic                         rsp_valid_ff;
   logic signed [SPEED_W-1:0]    rsp_speed_ff;
   logic                         rsp_sat_ff;

   logic signed [DELTA_W-1:0]    delta_raw;
   logic signed [DELTA_W-1:0]    delta_in;
   logic [ALPHA_W-1:0]           alpha_eff;
   logic signed [OPA_W-1:0]      mul_a;
   logic signed [OPB_W-1:0]      mul_b;
   logic signed [P_W-1:0]        prod_ff;
   logic signed [SPEED_W-1:0]    inst_in;
   logic                         inst_clip;
   logic signed [SUM_W-1:0]      sum_raw;
   logic signed [SPEED_W-1:0]    est_in;
   logic                         est_clip;

   assign out_free = !rsp_valid_ff || rsp_ready;

   aspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .have_prev (have_prev_ff),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // wrap the difference into [-pi, pi] once
   always_comb begin
      delta_raw = DELTA_W'(angle_ff) - DELTA_W'(prev_ff);
      priority if (delta_raw > PI_D) begin
         delta_in = delta_raw - TWO_PI_D;
      end else if (delta_raw < NEG_PI_D) begin
         delta_in = delta_raw + TWO_PI_D;
      end else begin
         delta_in = delta_raw;
      end
   end

   assign alpha_eff = ({1'b0, alpha_ff} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, alpha_ff};

   // operand select for the shared multiplier
   assign mul_a = ctrl.mul_alpha ? OPA_W'(diff_ff) : OPA_W'(delta_ff);
   assign mul_b = ctrl.mul_alpha ? $signed({1'b0, alpha_eff})
                                 : $signed({2'b00, rate_ff});

   aspd_mul #(
      .A_W (OPA_W),
      .B_W (OPB_W)
   ) u_mul (
      .clock   (clock),
      .en      (ctrl.mul_rate || ctrl.mul_alpha),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   always_comb begin
      inst_clip = 1'b1;
      priority if (prod_ff > P_MAX) begin
         inst_in = SPD_MAX;
      end else if (prod_ff < P_MIN) begin
         inst_in = SPD_MIN;
      end else begin
         inst_in   = prod_ff[SPEED_W-1:0];
         inst_clip = 1'b0;
      end
   end

   // arithmetic shift floors the Q1.15 weighting
   assign sum_raw = SUM_W'(est_ff) + SUM_W'(prod_ff >>> ALPHA_FRAC);

   always_comb begin
      est_clip = 1'b1;
      priority if (sum_raw > SUM_MAX) begin
         est_in = SPD_MAX;
      end else if (sum_raw < SUM_MIN) begin
         est_in = SPD_MIN;
      end else begin
         est_in   = sum_raw[SPEED_W-1:0];
         est_clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         rate_ff  <= RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ALPHA:       alpha_ff <= csr_wdata;
            REG_SAMPLE_RATE: rate_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         est_ff       <= '0;
      end else begin
         if (ctrl.delta) begin
            prev_ff      <= angle_ff;
            have_prev_ff <= 1'b1;
         end
         if (ctrl.update) begin
            est_ff <= est_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         angle_ff <= req_angle;
         sat_ff   <= 1'b0;
      end
      if (ctrl.delta) begin
         delta_ff <= delta_in;
      end
      if (ctrl.clip) begin
         diff_ff <= (SPEED_W+1)'(inst_in) - (SPEED_W+1)'(est_ff);
         sat_ff  <= inst_clip;
      end
      if (ctrl.update) begin
         sat_ff <= sat_ff || est_clip;
      end
   end

   // result register: hold until taken, load when free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_speed_ff <= est_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed     = rsp_speed_ff;
   assign rsp_saturated = rsp_sat_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_est_needs_prev, clock, reset, est_ff != '0, have_prev_ff)
   `ASSERT_IMPLY(a_update_needs_prev, clock, reset, ctrl.update, have_prev_ff)

endmodule
